// ----- src/btsu_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and the logistic win-probability table for the
// Bradley-Terry score update block. Used by every module except the RAM.
package btsu_pkg;

    localparam int PAIR_SLOTS    = 64;
    localparam int MAX_CELLS     = 256;
    localparam int SLOT_W        = $clog2(PAIR_SLOTS);
    localparam int HELD_W        = $clog2(PAIR_SLOTS + 1);
    localparam int CELL_W        = $clog2(MAX_CELLS);
    localparam int CELLS_CFG_W   = 9;
    localparam int LR_W          = 16;
    localparam int CFG_DATA_W    = 16;
    localparam int SCORE_W       = 17;
    localparam int CNT_W         = 48;
    localparam int QUEUE_DEPTH   = 2;
    localparam int LOGISTIC_SIZE = 129;

    localparam logic [SCORE_W-1:0] ONE_Q16  = 17'd65536;
    localparam logic [SCORE_W-1:0] HALF_Q16 = 17'd32768;
    localparam logic [7:0]         Q_LIMIT  = 8'd128;

    localparam logic [1:0] OP_RECORD = 2'd0;
    localparam logic [1:0] OP_PASS   = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] KIND_RECORD = 2'd0;
    localparam logic [1:0] KIND_PASS   = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    localparam logic REG_LEARNING_RATE = 1'b0;
    localparam logic REG_CELLS_IN_USE  = 1'b1;

    typedef struct packed {
        logic              won;
        logic [CELL_W-1:0] cell_idx;
        logic [15:0]       lose;
        logic [15:0]       win;
    } pair_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [SLOT_W-1:0] slot;
        logic [HELD_W-1:0] count;
        pair_t             pair;
    } cmd_t;

    typedef struct packed {
        logic [LR_W-1:0]        lr;
        logic [CELLS_CFG_W-1:0] cells;
    } cfg_t;

    typedef struct packed {
        logic [CELL_W-1:0]  cell_idx;
        logic [SCORE_W-1:0] score;
        logic               changed;
        logic [CNT_W-1:0]   updates;
        logic [CNT_W-1:0]   flips;
        logic               last;
    } result_t;

    function automatic logic [LOGISTIC_SIZE-1:0][15:0] build_logistic();
        logic [63:0] e;
        logic [63:0] d;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] quo;
        logic [LOGISTIC_SIZE-1:0][15:0] t;
        e = 64'h1_0000_0000;
        t = '0;
        for (int k = 0; k < LOGISTIC_SIZE; k++)
        begin
            d   = 64'h1_0000_0000 + e;
            num = 64'h1_0000_0000_0000 + (d >> 1);
            rem = '0;
            quo = '0;
            for (int b = 48; b >= 0; b--)
            begin
                rem = {rem[62:0], num[b]};
                if (rem >= d)
                begin
                    rem    = rem - d;
                    quo[b] = 1'b1;
                end
            end
            t[k] = quo[15:0];
            e = (e * 64'd4034748384 + 64'h8000_0000) >> 32;
        end
        return t;
    endfunction

    localparam logic [LOGISTIC_SIZE-1:0][15:0] LOGISTIC = build_logistic();

endpackage

// ----- src/btsu_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module btsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/btsu_front.sv -----
`timescale 1ns / 1ps
// Front end: takes commands, drops unused codes, assigns pair slots and
// snapshots the pair count for update passes. Depends on btsu_pkg.
module btsu_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  full,
    input  logic [1:0]            op,
    input  logic [63:0]           batch_number,
    input  logic [15:0]           winner_fitness,
    input  logic [15:0]           loser_fitness,
    input  logic [7:0]            cell_index,
    input  logic                  did_win,
    output logic                  push,
    output btsu_pkg::cmd_t        cmd
);
    import btsu_pkg::*;

    logic [HELD_W-1:0] held_reg;
    logic [HELD_W-1:0] held_next;
    logic              accept;
    logic              room;

    assign accept = start && !full;
    assign room   = (held_reg < HELD_W'(PAIR_SLOTS));

    always_comb
    begin
        held_next         = held_reg;
        push              = 1'b0;
        cmd.kind          = KIND_RECORD;
        cmd.slot          = room ? held_reg[SLOT_W-1:0] : batch_number[SLOT_W-1:0];
        cmd.count         = held_reg;
        cmd.pair.won      = did_win;
        cmd.pair.cell_idx = cell_index;
        cmd.pair.lose     = loser_fitness;
        cmd.pair.win      = winner_fitness;
        if (accept)
        begin
            unique case (op)
                OP_RECORD:
                begin
                    push     = 1'b1;
                    cmd.kind = KIND_RECORD;
                    if (room)
                    begin
                        held_next = held_reg + 1'b1;
                    end
                end
                OP_PASS:
                begin
                    push     = 1'b1;
                    cmd.kind = KIND_PASS;
                end
                OP_READ:
                begin
                    push     = 1'b1;
                    cmd.kind = KIND_READ;
                end
                OP_UNUSED:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else
        begin
            held_reg <= held_next;
        end
    end

endmodule

// ----- src/btsu_queue.sv -----
`timescale 1ns / 1ps
// Short command queue between front and back ends.
// Depends on btsu_pkg.
module btsu_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  btsu_pkg::cmd_t push_cmd,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output btsu_pkg::cmd_t head
);
    import btsu_pkg::*;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;

    assign full      = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// ----- src/btsu_back.sv -----
`timescale 1ns / 1ps
// Back end: executes queued commands against the pair store and score RAMs,
// runs the per-pair update sequence and drives results. Depends on btsu_pkg.
module btsu_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  btsu_pkg::cfg_t               cfg,
    input  logic                         q_valid,
    input  btsu_pkg::cmd_t               q_head,
    output logic                         q_pop,
    output logic                         pair_wr_en,
    output logic [btsu_pkg::SLOT_W-1:0]  pair_wr_addr,
    output btsu_pkg::pair_t              pair_wr_data,
    output logic                         pair_rd_en,
    output logic [btsu_pkg::SLOT_W-1:0]  pair_rd_addr,
    input  btsu_pkg::pair_t              pair_rd_data,
    output logic                         score_wr_en,
    output logic [btsu_pkg::CELL_W-1:0]  score_wr_addr,
    output logic [btsu_pkg::SCORE_W-1:0] score_wr_data,
    output logic                         score_rd_en,
    output logic [btsu_pkg::CELL_W-1:0]  score_rd_addr,
    input  logic [btsu_pkg::SCORE_W-1:0] score_rd_data,
    output logic                         result_valid,
    output btsu_pkg::result_t            result
);
    import btsu_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_DEC  = 3'd2;
    localparam logic [2:0] ST_PROB = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_WB   = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [HELD_W-1:0]   count_reg, count_next;
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    logic [CELL_W-1:0]   cell_reg, cell_next;
    logic                won_reg, won_next;
    logic                neg_reg, neg_next;
    logic [7:0]          qabs_reg, qabs_next;
    logic [15:0]         pw_reg, pw_next;
    logic [15:0]         delta_reg, delta_next;
    logic                in_range_reg, in_range_next;
    logic [CNT_W-1:0]    upd_reg, upd_next;
    logic [CNT_W-1:0]    flip_reg, flip_next;
    logic                sv_reg;
    logic [MAX_CELLS-1:0] valid_reg;
    logic                res_valid_reg, res_valid_next;
    result_t             res_reg, res_next;

    logic [CELL_W-1:0]   last_cell;
    logic signed [16:0]  margin;
    logic signed [17:0]  biased;
    logic signed [13:0]  qv;
    logic [16:0]         pw_flip;
    logic [16:0]         factor;
    logic [32:0]         prod;
    logic [SCORE_W-1:0]  prior_score;
    logic [17:0]         raised;
    logic [SCORE_W-1:0]  new_score;
    logic                changed;
    logic                last_pair;

    always_comb
    begin
        if (cfg.cells == '0)
        begin
            last_cell = '0;
        end
        else if (cfg.cells > CELLS_CFG_W'(MAX_CELLS))
        begin
            last_cell = CELL_W'(MAX_CELLS - 1);
        end
        else
        begin
            last_cell = CELL_W'(cfg.cells - 1'b1);
        end
    end

    assign margin      = $signed({pair_rd_data.win[15], pair_rd_data.win})
                       - $signed({pair_rd_data.lose[15], pair_rd_data.lose});
    assign biased      = $signed({margin[16], margin}) + 18'sd8;
    assign qv          = 14'(biased >>> 4);
    assign pw_flip     = 17'd65536 - {1'b0, LOGISTIC[qabs_reg]};
    assign factor      = won_reg ? (17'd65536 - {1'b0, pw_reg}) : {1'b0, pw_reg};
    assign prod        = {17'd0, cfg.lr} * {16'd0, factor} + 33'd32768;
    assign prior_score = sv_reg ? score_rd_data : HALF_Q16;
    assign raised      = {1'b0, prior_score} + {2'b00, delta_reg};
    assign last_pair   = ({1'b0, idx_reg} + 1'b1) == count_reg;

    always_comb
    begin
        if (won_reg)
        begin
            new_score = (raised > {1'b0, ONE_Q16}) ? ONE_Q16 : raised[SCORE_W-1:0];
        end
        else
        begin
            new_score = ({1'b0, delta_reg} > prior_score) ? '0
                                                          : prior_score - {1'b0, delta_reg};
        end
    end

    assign changed = (new_score != prior_score);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        cell_next      = cell_reg;
        won_next       = won_reg;
        neg_next       = neg_reg;
        qabs_next      = qabs_reg;
        pw_next        = pw_reg;
        delta_next     = delta_reg;
        in_range_next  = in_range_reg;
        upd_next       = upd_reg;
        flip_next      = flip_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        q_pop          = 1'b0;
        pair_wr_en     = 1'b0;
        pair_wr_addr   = q_head.slot;
        pair_wr_data   = q_head.pair;
        pair_rd_en     = 1'b0;
        pair_rd_addr   = '0;
        score_rd_en    = 1'b0;
        score_rd_addr  = q_head.pair.cell_idx;
        score_wr_en    = 1'b0;
        score_wr_addr  = cell_reg;
        score_wr_data  = new_score;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    unique case (q_head.kind)
                        KIND_RECORD:
                        begin
                            pair_wr_en = 1'b1;
                        end
                        KIND_READ:
                        begin
                            score_rd_en   = 1'b1;
                            cell_next     = q_head.pair.cell_idx;
                            in_range_next = (q_head.pair.cell_idx <= last_cell);
                            state_next    = ST_RD;
                        end
                        KIND_PASS:
                        begin
                            count_next = q_head.count;
                            idx_next   = '0;
                            if (q_head.count != '0)
                            begin
                                pair_rd_en = 1'b1;
                                state_next = ST_DEC;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_RD:
            begin
                res_valid_next    = 1'b1;
                res_next.cell_idx = cell_reg;
                res_next.score    = (in_range_reg && sv_reg) ? score_rd_data : HALF_Q16;
                res_next.changed  = 1'b0;
                res_next.updates  = upd_reg;
                res_next.flips    = flip_reg;
                res_next.last     = 1'b1;
                state_next        = ST_IDLE;
            end
            ST_DEC:
            begin
                cell_next     = (pair_rd_data.cell_idx > last_cell) ? last_cell
                                                                    : pair_rd_data.cell_idx;
                won_next      = pair_rd_data.won;
                score_rd_en   = 1'b1;
                score_rd_addr = cell_next;
                if (qv > 14'sd128)
                begin
                    neg_next  = 1'b0;
                    qabs_next = Q_LIMIT;
                end
                else if (qv < -14'sd128)
                begin
                    neg_next  = 1'b1;
                    qabs_next = Q_LIMIT;
                end
                else
                begin
                    neg_next  = qv[13];
                    qabs_next = qv[13] ? 8'(-qv) : 8'(qv);
                end
                state_next = ST_PROB;
            end
            ST_PROB:
            begin
                pw_next    = neg_reg ? pw_flip[15:0] : LOGISTIC[qabs_reg];
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                delta_next = prod[31:16];
                state_next = ST_WB;
            end
            ST_WB:
            begin
                score_wr_en       = 1'b1;
                upd_next          = upd_reg + 1'b1;
                flip_next         = changed ? flip_reg + 1'b1 : flip_reg;
                res_valid_next    = 1'b1;
                res_next.cell_idx = cell_reg;
                res_next.score    = new_score;
                res_next.changed  = changed;
                res_next.updates  = upd_next;
                res_next.flips    = flip_next;
                res_next.last     = last_pair;
                if (last_pair)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next     = idx_reg + 1'b1;
                    pair_rd_en   = 1'b1;
                    pair_rd_addr = idx_next;
                    state_next   = ST_DEC;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (state_reg == ST_IDLE)
        begin
            pair_rd_addr = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg    <= count_next;
        idx_reg      <= idx_next;
        cell_reg     <= cell_next;
        won_reg      <= won_next;
        neg_reg      <= neg_next;
        qabs_reg     <= qabs_next;
        pw_reg       <= pw_next;
        delta_reg    <= delta_next;
        in_range_reg <= in_range_next;
        res_reg      <= res_next;
        if (score_rd_en)
        begin
            sv_reg <= valid_reg[score_rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            upd_reg       <= '0;
            flip_reg      <= '0;
            valid_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            upd_reg       <= upd_next;
            flip_reg      <= flip_next;
            res_valid_reg <= res_valid_next;
            if (score_wr_en)
            begin
                valid_reg[score_wr_addr] <= 1'b1;
            end
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ST_IDLE) && q_valid)
        else $error("command popped while back end busy");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> ($past(state_reg) == ST_WB) || ($past(state_reg) == ST_RD))
        else $error("result strobe without a producing step");

    a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_reg.score <= ONE_Q16))
        else $error("score above one");

    a_flip_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_WB) |=> $stable(flip_reg) && $stable(upd_reg))
        else $error("counters moved outside write-back");

endmodule

// ----- src/bradley_terry_score_update.sv -----
`timescale 1ns / 1ps
// Top level of the Bradley-Terry online score update block.
// Depends on btsu_pkg, btsu_front, btsu_queue, btsu_back and btsu_ram.
//
// Commands are taken when start is high and busy is low; busy rises only
// while the two-word command queue is full. The back end stores a record
// word in the pair RAM, a read yields one result, and an update pass
// steps through the stored pairs in turn (pair RAM read, probability
// table lookup, lr multiply, score write-back), giving one result word
// per pair with last set on the final one. A pass with no pairs and op
// code 3 yield nothing. Results appear on result_valid for a
// single cycle and cannot be held off. Scores read as 0.5 until first
// written, tracked by one valid bit per cell, so no clearing pass runs
// after reset. Write configuration only while the block is idle.
module bradley_terry_score_update (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic                          cfg_index,
    input  logic [btsu_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    op,
    input  logic [63:0]                   batch_number,
    input  logic [15:0]                   winner_fitness,
    input  logic [15:0]                   loser_fitness,
    input  logic [7:0]                    cell_index,
    input  logic                          did_win,
    output logic                          result_valid,
    output logic [7:0]                    result_cell,
    output logic [16:0]                   score,
    output logic                          changed,
    output logic [47:0]                   total_updates,
    output logic [47:0]                   total_flips,
    output logic                          last
);
    import btsu_pkg::*;

    cfg_t                cfg_reg;
    logic                push;
    cmd_t                push_cmd;
    logic                full;
    logic                q_valid;
    cmd_t                q_head;
    logic                q_pop;
    logic                pair_wr_en;
    logic [SLOT_W-1:0]   pair_wr_addr;
    pair_t               pair_wr_data;
    logic                pair_rd_en;
    logic [SLOT_W-1:0]   pair_rd_addr;
    pair_t               pair_rd_data;
    logic                score_wr_en;
    logic [CELL_W-1:0]   score_wr_addr;
    logic [SCORE_W-1:0]  score_wr_data;
    logic                score_rd_en;
    logic [CELL_W-1:0]   score_rd_addr;
    logic [SCORE_W-1:0]  score_rd_data;
    result_t             result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lr    <= 16'd3277;
            cfg_reg.cells <= 9'd256;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_LEARNING_RATE: cfg_reg.lr    <= cfg_data[LR_W-1:0];
                REG_CELLS_IN_USE:  cfg_reg.cells <= cfg_data[CELLS_CFG_W-1:0];
            endcase
        end
    end

    assign busy = full;

    btsu_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .full           (full),
        .op             (op),
        .batch_number   (batch_number),
        .winner_fitness (winner_fitness),
        .loser_fitness  (loser_fitness),
        .cell_index     (cell_index),
        .did_win        (did_win),
        .push           (push),
        .cmd            (push_cmd)
    );

    btsu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (q_pop),
        .full      (full),
        .not_empty (q_valid),
        .head      (q_head)
    );

    btsu_ram #(
        .WIDTH ($bits(pair_t)),
        .DEPTH (PAIR_SLOTS)
    ) u_pair_ram (
        .clk     (clk),
        .wr_en   (pair_wr_en),
        .wr_addr (pair_wr_addr),
        .wr_data (pair_wr_data),
        .rd_en   (pair_rd_en),
        .rd_addr (pair_rd_addr),
        .rd_data (pair_rd_data)
    );

    btsu_ram #(
        .WIDTH (SCORE_W),
        .DEPTH (MAX_CELLS)
    ) u_score_ram (
        .clk     (clk),
        .wr_en   (score_wr_en),
        .wr_addr (score_wr_addr),
        .wr_data (score_wr_data),
        .rd_en   (score_rd_en),
        .rd_addr (score_rd_addr),
        .rd_data (score_rd_data)
    );

    btsu_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .pair_wr_en    (pair_wr_en),
        .pair_wr_addr  (pair_wr_addr),
        .pair_wr_data  (pair_wr_data),
        .pair_rd_en    (pair_rd_en),
        .pair_rd_addr  (pair_rd_addr),
        .pair_rd_data  (pair_rd_data),
        .score_wr_en   (score_wr_en),
        .score_wr_addr (score_wr_addr),
        .score_wr_data (score_wr_data),
        .score_rd_en   (score_rd_en),
        .score_rd_addr (score_rd_addr),
        .score_rd_data (score_rd_data),
        .result_valid  (result_valid),
        .result        (result)
    );

    assign result_cell   = result.cell_idx;
    assign score         = result.score;
    assign changed       = result.changed;
    assign total_updates = result.updates;
    assign total_flips   = result.flips;
    assign last          = result.last;

endmodule

// ----- bench/tb_bradley_terry_score_update.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for bradley_terry_score_update: directed and random
// command words, every result word compared against an in-bench score predictor.
// Depends on btsu_pkg and the bradley_terry_score_update RTL.
module tb_bradley_terry_score_update;
    import btsu_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_WORDS  = 20;
    localparam int PHASES        = 4;

    typedef struct {
        logic [7:0]  cell_id;
        logic [16:0] score;
        logic        changed;
        logic [47:0] updates;
        logic [47:0] flips;
        logic        last;
    } score_word_t;

    typedef struct {
        logic signed [15:0] win;
        logic signed [15:0] lose;
        logic [7:0]         cell_id;
        logic               won;
    } outcome_t;

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        cfg_write      = 1'b0;
    logic        cfg_index      = REG_LEARNING_RATE;
    logic [15:0] cfg_data       = '0;
    logic        start          = 1'b0;
    logic        busy;
    logic [1:0]  op             = OP_READ;
    logic [63:0] batch_number   = '0;
    logic [15:0] winner_fitness = '0;
    logic [15:0] loser_fitness  = '0;
    logic [7:0]  cell_index     = '0;
    logic        did_win        = 1'b0;
    logic        result_valid;
    logic [7:0]  result_cell;
    logic [16:0] score;
    logic        changed;
    logic [47:0] total_updates;
    logic [47:0] total_flips;
    logic        last;

    // predictor state
    int unsigned sigmoid_lut[129];
    logic [16:0] cell_score[256];
    outcome_t    outcome_store[64];
    int          outcomes_held;
    logic [47:0] update_count;
    logic [47:0] flip_count;
    logic [15:0] lr_setting;
    logic [8:0]  cells_setting;
    score_word_t pending_scores[$];
    int          errors;
    int          burst_left;

    bradley_terry_score_update dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .batch_number   (batch_number),
        .winner_fitness (winner_fitness),
        .loser_fitness  (loser_fitness),
        .cell_index     (cell_index),
        .did_win        (did_win),
        .result_valid   (result_valid),
        .result_cell    (result_cell),
        .score          (score),
        .changed        (changed),
        .total_updates  (total_updates),
        .total_flips    (total_flips),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("** bradley_terry_score_update: FAILED **");
        $finish;
    end

    function automatic void reset_predictor();
        longint unsigned e;
        longint unsigned d;
        e = 64'd1 << 32;
        for (int k = 0; k < 129; k++)
        begin
            d = (64'd1 << 32) + e;
            sigmoid_lut[k] = 32'(((64'd1 << 48) + (d >> 1)) / d);
            e = (e * 64'd4034748384 + (64'd1 << 31)) >> 32;
        end
        foreach (cell_score[i])
            cell_score[i] = HALF_Q16;
        outcomes_held = 0;
        update_count  = '0;
        flip_count    = '0;
        lr_setting    = 16'd3277;
        cells_setting = 9'd256;
        errors        = 0;
        burst_left    = 1;
    endfunction

    function automatic longint win_chance(int margin);
        int q;
        q = (margin + 8) >>> 4;
        if (q > 128)
            q = 128;
        if (q < -128)
            q = -128;
        return (q >= 0) ? longint'(sigmoid_lut[q]) : 65536 - longint'(sigmoid_lut[-q]);
    endfunction

    function automatic int live_cells();
        int n;
        n = int'(cells_setting);
        if (n == 0)
            n = 1;
        if (n > MAX_CELLS)
            n = MAX_CELLS;
        return n;
    endfunction

    function automatic void predict_word(logic [1:0] op_code, logic [63:0] batch,
                                         logic [15:0] win, logic [15:0] lose,
                                         logic [7:0] cell_no, logic won);
        int          n;
        int          slot;
        int          c;
        longint      pw;
        longint      s;
        logic [16:0] prior;
        score_word_t w;
        n = live_cells();
        case (op_code)
            OP_RECORD:
            begin
                if (outcomes_held < PAIR_SLOTS)
                begin
                    slot = outcomes_held;
                    outcomes_held++;
                end
                else
                    slot = int'(batch[SLOT_W-1:0]);
                outcome_store[slot].win     = win;
                outcome_store[slot].lose    = lose;
                outcome_store[slot].cell_id = cell_no;
                outcome_store[slot].won     = won;
            end
            OP_PASS:
            begin
                for (int i = 0; i < outcomes_held; i++)
                begin
                    c = int'(outcome_store[i].cell_id);
                    if (c >= n)
                        c = n - 1;
                    pw = win_chance(int'(outcome_store[i].win) - int'(outcome_store[i].lose));
                    prior = cell_score[c];
                    s = longint'(prior);
                    if (outcome_store[i].won)
                        s = s + ((longint'(lr_setting) * (65536 - pw) + 32768) >>> 16);
                    else
                        s = s - ((longint'(lr_setting) * pw + 32768) >>> 16);
                    if (s > 65536)
                        s = 65536;
                    if (s < 0)
                        s = 0;
                    cell_score[c] = s[16:0];
                    w.cell_id = c[7:0];
                    w.score   = s[16:0];
                    w.changed = (s[16:0] != prior);
                    if (w.changed)
                        flip_count = flip_count + 48'd1;
                    update_count = update_count + 48'd1;
                    w.updates = update_count;
                    w.flips   = flip_count;
                    w.last    = (i == outcomes_held - 1);
                    pending_scores.push_back(w);
                end
            end
            OP_READ:
            begin
                w.cell_id = cell_no;
                w.score   = (int'(cell_no) < n) ? cell_score[cell_no] : HALF_Q16;
                w.changed = 1'b0;
                w.updates = update_count;
                w.flips   = flip_count;
                w.last    = 1'b1;
                pending_scores.push_back(w);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        score_word_t due;
        if (rst_n && result_valid)
        begin
            if (pending_scores.size() == 0)
            begin
                $display("%0t: unexpected word: expected none, got cell %0d score %0d",
                         $time, result_cell, score);
                errors++;
            end
            else
            begin
                due = pending_scores.pop_front();
                check_field("result_cell", due.cell_id, result_cell);
                check_field("score", due.score, score);
                check_field("changed", due.changed, changed);
                check_field("total_updates", due.updates, total_updates);
                check_field("total_flips", due.flips, total_flips);
                check_field("last", due.last, last);
            end
        end
    end

    function automatic logic [63:0] random_batch();
        return {$urandom, $urandom};
    endfunction

    task automatic send_word(logic [1:0] op_code, logic [63:0] batch, logic [15:0] win,
                             logic [15:0] lose, logic [7:0] cell_no, logic won);
        start          <= 1'b1;
        op             <= op_code;
        batch_number   <= batch;
        winner_fitness <= win;
        loser_fitness  <= lose;
        cell_index     <= cell_no;
        did_win        <= won;
        do
            @(posedge clk);
        while (busy);
        predict_word(op_code, batch, win, lose, cell_no, won);
    endtask

    task automatic hold_off(int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // hold until every expected word is back, then let the design settle
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_scores.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == REG_LEARNING_RATE)
            lr_setting = value;
        else
            cells_setting = value[8:0];
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic pace();
        burst_left--;
        if (burst_left <= 0)
        begin
            hold_off($urandom_range(1, 7));
            burst_left = $urandom_range(1, 10);
        end
    endtask

    task automatic send_random_word(logic [1:0] op_code);
        logic [15:0] win;
        logic [15:0] lose;
        logic [7:0]  cell_no;
        win = 16'($urandom);
        if ($urandom_range(0, 1))
            lose = 16'($urandom);
        else
            lose = win + 16'($urandom_range(0, 4200)) - 16'd2100;
        cell_no = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 7));
        send_word(op_code, random_batch(), win, lose, cell_no, 1'($urandom));
        pace();
    endtask

    function automatic logic [1:0] random_op();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return OP_RECORD;
        if (pick < 65)
            return OP_PASS;
        if (pick < 95)
            return OP_READ;
        return OP_UNUSED;
    endfunction

    task automatic test_reset_reads();
        send_word(OP_READ, random_batch(), 16'($urandom), 16'($urandom), 8'd0, 1'($urandom));
        send_word(OP_READ, random_batch(), 16'($urandom), 16'($urandom), 8'd255, 1'($urandom));
        drain();
    endtask

    task automatic test_empty_and_unused();
        send_word(OP_PASS, random_batch(), 16'($urandom), 16'($urandom), 8'd3, 1'b1);
        send_word(OP_UNUSED, random_batch(), 16'($urandom), 16'($urandom), 8'd4, 1'b0);
        drain();
    endtask

    task automatic test_extreme_pairs();
        send_word(OP_RECORD, '1, 16'h7fff, 16'h8000, 8'd0, 1'b1);
        send_word(OP_RECORD, '0, 16'h8000, 16'h7fff, 8'd255, 1'b0);
        send_word(OP_RECORD, random_batch(), 16'h1234, 16'h1234, 8'd1, 1'b1);
        send_word(OP_RECORD, random_batch(), 16'h0000, 16'h0008, 8'd2, 1'b0);
        send_word(OP_PASS, random_batch(), 16'($urandom), 16'($urandom), 8'd0, 1'b0);
        send_word(OP_READ, random_batch(), 16'($urandom), 16'($urandom), 8'd0, 1'b0);
        send_word(OP_READ, random_batch(), 16'($urandom), 16'($urandom), 8'd255, 1'b1);
        drain();
    endtask

    task automatic test_cell_count();
        write_reg(REG_CELLS_IN_USE, 16'd0);
        send_word(OP_RECORD, random_batch(), 16'h0100, 16'h0000, 8'd200, 1'b1);
        send_word(OP_PASS, random_batch(), 16'($urandom), 16'($urandom), 8'd0, 1'b0);
        send_word(OP_READ, random_batch(), 16'($urandom), 16'($urandom), 8'd200, 1'b0);
        drain();
        write_reg(REG_CELLS_IN_USE, 16'd511);
        send_word(OP_READ, random_batch(), 16'($urandom), 16'($urandom), 8'd200, 1'b0);
        send_word(OP_READ, random_batch(), 16'($urandom), 16'($urandom), 8'd0, 1'b0);
        drain();
    endtask

    task automatic test_learning_rate();
        write_reg(REG_LEARNING_RATE, 16'd0);
        send_word(OP_PASS, random_batch(), 16'($urandom), 16'($urandom), 8'd0, 1'b0);
        drain();
        write_reg(REG_LEARNING_RATE, 16'hffff);
        send_word(OP_PASS, random_batch(), 16'($urandom), 16'($urandom), 8'd0, 1'b0);
        send_word(OP_PASS, random_batch(), 16'($urandom), 16'($urandom), 8'd0, 1'b0);
        send_word(OP_READ, random_batch(), 16'($urandom), 16'($urandom), 8'd1, 1'b0);
        send_word(OP_READ, random_batch(), 16'($urandom), 16'($urandom), 8'd2, 1'b0);
        drain();
    endtask

    task automatic test_store_overwrite();
        write_reg(REG_LEARNING_RATE, 16'($urandom_range(1, 65535)));
        write_reg(REG_CELLS_IN_USE, 16'd256);
        while (outcomes_held < PAIR_SLOTS)
            send_random_word(OP_RECORD);
        repeat (8) send_random_word(OP_RECORD);
        send_random_word(OP_PASS);
        drain();
    endtask

    task automatic test_random();
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(REG_LEARNING_RATE, 16'($urandom_range(1, 65535)));
                    write_reg(REG_CELLS_IN_USE, 16'($urandom_range(1, 256)));
                end
                1:
                begin
                    write_reg(REG_LEARNING_RATE, 16'd1);
                    write_reg(REG_CELLS_IN_USE, 16'd1);
                end
                2:
                begin
                    write_reg(REG_LEARNING_RATE, 16'hffff);
                    write_reg(REG_CELLS_IN_USE, 16'd256);
                end
                default:
                begin
                    write_reg(REG_LEARNING_RATE, 16'($urandom_range(0, 65535)));
                    write_reg(REG_CELLS_IN_USE, 16'($urandom_range(0, 511)));
                end
            endcase
            repeat (RANDOM_WORDS / PHASES) send_random_word(random_op());
            drain();
        end
    endtask

    initial
    begin
        reset_predictor();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_reads();
        test_empty_and_unused();
        test_extreme_pairs();
        test_cell_count();
        test_learning_rate();
        test_store_overwrite();
        test_random();
        drain();
        if (errors == 0 && pending_scores.size() == 0)
            $display("** bradley_terry_score_update: PASSED **");
        else
            $display("** bradley_terry_score_update: FAILED **");
        $finish;
    end

endmodule

// ----- bradley_terry_score_update.f -----
src/btsu_pkg.sv
src/btsu_ram.sv
src/btsu_front.sv
src/btsu_queue.sv
src/btsu_back.sv
src/bradley_terry_score_update.sv
bench/tb_bradley_terry_score_update.sv
